// File: rtl/lfbd_pkg.sv
// Package for the LED flash and breathing driver: widths, codes, types and the sine table.
`default_nettype none

package lfbd_pkg;

    localparam int SINE_BITS    = 10;
    localparam int SINE_ENTRIES = 1 << SINE_BITS;
    localparam int FULL_DUTY    = 500;

    localparam int DUTY_W   = 9;
    localparam int TIME_W   = 16;
    localparam int PHASE_W  = 16;
    localparam int SINCE_W  = 17;
    localparam int CFG_IDX_W = 8;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 16;
    localparam int CNT_W    = $clog2((PHASE_W > SINE_BITS) ? PHASE_W : SINE_BITS);

    localparam logic [SINCE_W-1:0] SINCE_MAX  = {SINCE_W{1'b1}};
    localparam logic [DUTY_W-1:0]  DUTY_FULL  = DUTY_W'(FULL_DUTY);
    localparam logic [DUTY_W-1:0]  DUTY_MID   = DUTY_W'(256);

    localparam int QBITS = 55;
    localparam longint unsigned TWO_PI_MICRO = 64'd6283184;
    localparam longint unsigned MICRO        = 64'd1000000;
    localparam longint unsigned SINE_DEN     = MICRO * longint'(SINE_ENTRIES);

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_FLASH  = 2'd2,
        MODE_BREATH = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_LED_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LIT_TIME     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DARK_TIME    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_PERIOD = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_ADV,
        ST_IDX,
        ST_ROM,
        ST_APPLY
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic advance;
        logic idx_step;
        logic rom_read;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic period_zero;
    } dp_status_t;

    typedef logic [SINE_ENTRIES-1:0][DUTY_W-1:0] sine_lut_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[QBITS+63:QBITS];
    endfunction

    // Restoring shift-and-subtract quotient, used only while the table is built.
    function automatic logic [63:0] div_floor(input logic [63:0] a, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          i;
        r = 65'd0;
        q = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [DUTY_W-1:0] breath_entry(input int unsigned idx);
        logic [63:0] num;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] u;
        logic [63:0] n;
        int          b;
        num   = 64'(idx) * TWO_PI_MICRO;
        whole = div_floor(num, SINE_DEN);
        rem   = num - whole * SINE_DEN;
        frac  = 64'd0;
        pos   = 64'd0;
        neg   = 64'd0;
        for (b = 0; b < QBITS; b++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= SINE_DEN)
            begin
                rem  = rem - SINE_DEN;
                frac = frac | 64'd1;
            end
        end
        x  = (whole << QBITS) | frac;
        x2 = qmul(x, x);
        t  = x;
        n  = 64'd1;
        while (t != 64'd0 && n < 64'd80)
        begin
            if (n[1])
                neg = neg + t;
            else
                pos = pos + t;
            t = qmul(div_floor(t, (n + 64'd1) * (n + 64'd2)), x2);
            n = n + 64'd2;
        end
        u = 64'd256 << QBITS;
        if (pos >= neg)
            u = u + 64'd240 * (pos - neg);
        else
            u = u - 64'd240 * (neg - pos);
        return u[QBITS+DUTY_W-1:QBITS];
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        int        i;
        for (i = 0; i < SINE_ENTRIES; i++)
        begin
            lut[i] = breath_entry(i);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// File: rtl/led_flash_and_breathe_driver_core.sv
// Top level of the LED flash and breathing driver.
// With a nonzero breathing period an input beat passes through 16 remainder steps, one
// advance, 10 index steps, a ROM read and the update before its result beat is offered;
// with a zero period it goes from the load to the advance and the update. A new item is
// taken only after the last one's update; the restoring divider is shared, one bit per cycle.
// Reset clears the configuration, mode, timers and duty; the output register may hold a beat
// while the next item is taken, and that item then waits in its update step.
`default_nettype none

module led_flash_and_breathe_driver_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lfbd_pkg::IN_W-1:0]        s_tdata,   // [0] tick
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lfbd_pkg::OUT_W-1:0]            m_tdata,   // [8:0] duty_level, [9] flash_lit
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lfbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lfbd_pkg::TIME_W-1:0]      cfg_data
);
    import lfbd_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [DUTY_W-1:0] duty_level;
    logic              flash_lit;

    assign cfg_ready = 1'b1;

    lfbd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lfbd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .tick       (s_tdata[0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .duty_level (duty_level),
        .flash_lit  (flash_lit)
    );

    assign m_tdata = {(OUT_W - DUTY_W - 1)'(0), flash_lit, duty_level};

endmodule

`default_nettype wire

// File: rtl/lfbd_datapath.sv
// Datapath of the LED driver: registers, shared restoring divider, sine ROM and duty logic.
`default_nettype none

module lfbd_datapath
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lfbd_pkg::dp_cmd_t                cmd,
    output lfbd_pkg::dp_status_t                  status,
    input  wire logic                             tick,
    input  wire logic                             cfg_we,
    input  wire logic [lfbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lfbd_pkg::TIME_W-1:0]      cfg_data,
    output logic [lfbd_pkg::DUTY_W-1:0]           duty_level,
    output logic                                  flash_lit
);
    import lfbd_pkg::*;

    mode_t               mode_reg;
    logic [TIME_W-1:0]   lit_time_reg;
    logic [TIME_W-1:0]   dark_time_reg;
    logic [TIME_W-1:0]   period_reg;

    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                lit_reg, lit_next;
    logic [SINCE_W-1:0]  since_reg, since_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                tick_reg;
    logic [PHASE_W-1:0]  shift_reg;
    logic [PHASE_W-1:0]  rem_reg, rem_next;
    logic [SINE_BITS-1:0] quo_reg;
    logic [DUTY_W-1:0]   rom_q_reg;

    logic [PHASE_W:0]    rem_sh;
    logic                rem_ge;
    logic [PHASE_W:0]    rem_sub;
    logic [PHASE_W:0]    phase_inc;
    logic [PHASE_W-1:0]  phase_adv;
    logic                period_zero;

    assign period_zero        = (period_reg == '0);
    assign status.period_zero = period_zero;

    assign rem_sh  = cmd.mod_step ? {rem_reg, shift_reg[PHASE_W-1]} : {rem_reg, 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, period_reg});
    assign rem_sub = rem_sh - {1'b0, period_reg};

    always_comb
    begin
        rem_next = rem_ge ? rem_sub[PHASE_W-1:0] : rem_sh[PHASE_W-1:0];
    end

    assign phase_inc = {1'b0, rem_reg} + (PHASE_W+1)'(1);

    always_comb
    begin
        if (period_zero)
            phase_adv = '0;
        else if (!tick_reg)
            phase_adv = rem_reg;
        else if (phase_inc >= {1'b0, period_reg})
            phase_adv = '0;
        else
            phase_adv = phase_inc[PHASE_W-1:0];
    end

    always_comb
    begin
        duty_next  = duty_reg;
        lit_next   = lit_reg;
        since_next = since_reg;
        phase_next = phase_reg;
        if (cfg_we && cfg_index == REG_LED_MODE)
        begin
            since_next = '0;
            phase_next = '0;
        end
        else if (cmd.advance)
        begin
            phase_next = phase_adv;
            if (tick_reg && since_reg != SINCE_MAX)
                since_next = since_reg + SINCE_W'(1);
        end
        else if (cmd.apply)
        begin
            unique case (mode_reg)
                MODE_OFF:
                begin
                    duty_next = '0;
                end
                MODE_ON:
                begin
                    duty_next = DUTY_FULL;
                end
                MODE_FLASH:
                begin
                    if (lit_next && since_next > {1'b0, lit_time_reg})
                    begin
                        duty_next  = '0;
                        since_next = '0;
                        lit_next   = 1'b0;
                    end
                    if (!lit_next && since_next > {1'b0, dark_time_reg})
                    begin
                        duty_next  = DUTY_FULL;
                        since_next = '0;
                        lit_next   = 1'b1;
                    end
                end
                MODE_BREATH:
                begin
                    duty_next = period_zero ? DUTY_MID : rom_q_reg;
                end
                default:
                begin
                    duty_next = duty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            lit_time_reg  <= '0;
            dark_time_reg <= '0;
            period_reg    <= '0;
            duty_reg      <= '0;
            lit_reg       <= 1'b0;
            since_reg     <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LED_MODE:      mode_reg      <= mode_t'(cfg_data[1:0]);
                    REG_LIT_TIME:      lit_time_reg  <= cfg_data;
                    REG_DARK_TIME:     dark_time_reg <= cfg_data;
                    REG_BREATH_PERIOD: period_reg    <= cfg_data;
                    default:           mode_reg      <= mode_reg;
                endcase
            end
            duty_reg  <= duty_next;
            lit_reg   <= lit_next;
            since_reg <= since_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tick_reg  <= tick;
            shift_reg <= phase_reg;
            rem_reg   <= '0;
        end
        else if (cmd.mod_step)
        begin
            shift_reg <= {shift_reg[PHASE_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
        else if (cmd.advance)
        begin
            rem_reg <= phase_adv;
            quo_reg <= '0;
        end
        else if (cmd.idx_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SINE_BITS-2:0], rem_ge};
        end
        if (cmd.rom_read)
            rom_q_reg <= SINE_LUT[quo_reg];
    end

    assign duty_level = duty_reg;
    assign flash_lit  = lit_reg;

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL || duty_reg == DUTY_MID)
        else $error("duty level out of range");

    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> (phase_reg < period_reg || phase_reg == '0))
        else $error("phase not reduced below the period");

    a_since_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && lit_reg != lit_next) |=> since_reg == '0)
        else $error("flash timer not restarted at a phase change");

endmodule

`default_nettype wire

// File: rtl/lfbd_ctrl.sv
// Controller of the LED driver: sequences the divider passes, ROM read and result beat.
`default_nettype none

module lfbd_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire lfbd_pkg::dp_status_t  status,
    output lfbd_pkg::dp_cmd_t          cmd
);
    import lfbd_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.period_zero ? ST_ADV : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PHASE_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                cnt_next    = '0;
                state_next  = status.period_zero ? ST_APPLY : ST_IDX;
            end
            ST_IDX:
            begin
                cmd.idx_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SINE_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROM;
                end
            end
            ST_ROM:
            begin
                cmd.rom_read = 1'b1;
                state_next   = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before its beat was taken");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is at work");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result beat raised outside the apply step");

endmodule

`default_nettype wire

// File: bench/led_duty_checker.sv
// Checker for the LED flash and breathing driver: watches the channels, predicts and compares.
module led_duty_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [lfbd_pkg::IN_W-1:0]        s_tdata,   // [0] tick
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [lfbd_pkg::OUT_W-1:0]       m_tdata,   // [8:0] duty_level, [9] flash_lit
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [lfbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lfbd_pkg::TIME_W-1:0]      cfg_data,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    beats_in,
    output int                                    beats_out
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfbd_pkg::*;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              lit;
    } led_level_t;

    led_level_t expected_levels[$];

    mode_t               cur_mode;
    logic [TIME_W-1:0]   lit_ms;
    logic [TIME_W-1:0]   dark_ms;
    logic [TIME_W-1:0]   breath_len;
    logic [DUTY_W-1:0]   duty_now;
    logic                lit_now;
    logic [SINCE_W-1:0]  since_ms;
    logic [PHASE_W-1:0]  phase_ms;

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] w;
        w = 128'(a) * 128'(b);
        return w[QBITS +: 64];
    endfunction

    // Sine of the table angle in Q55, summed as a Taylor series with the positive and
    // negative terms kept apart, then scaled to 256 + 240 * sin and truncated.
    function automatic logic [DUTY_W-1:0] sine_level(input logic [31:0] slot);
        logic [63:0] span;
        logic [63:0] top;
        logic [63:0] rest;
        logic [63:0] angle;
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] acc;
        logic [63:0] k;
        int          b;
        span  = 64'd1000000 * 64'(SINE_ENTRIES);
        top   = 64'(slot) * 64'd6283184;
        angle = top / span;
        rest  = top % span;
        for (b = 0; b < QBITS; b++)
        begin
            rest  = rest << 1;
            angle = angle << 1;
            if (rest >= span)
            begin
                rest  = rest - span;
                angle = angle | 64'd1;
            end
        end
        sq   = fx_mul(angle, angle);
        term = angle;
        up   = 64'd0;
        down = 64'd0;
        k    = 64'd1;
        while (term != 64'd0 && k < 64'd80)
        begin
            if (k[1])
                down = down + term;
            else
                up = up + term;
            term = fx_mul(term / ((k + 64'd1) * (k + 64'd2)), sq);
            k    = k + 64'd2;
        end
        acc = 64'd1 << 63;
        if (up >= down)
            acc = acc + 64'd240 * (up - down);
        else
            acc = acc - 64'd240 * (down - up);
        return acc[QBITS +: DUTY_W];
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        case (idx)
            REG_LED_MODE:
            begin
                cur_mode = mode_t'(data[1:0]);
                since_ms = '0;
                phase_ms = '0;
            end
            REG_LIT_TIME:      lit_ms = data;
            REG_DARK_TIME:     dark_ms = data;
            REG_BREATH_PERIOD: breath_len = data;
            default:           ;
        endcase
    endtask

    task automatic advance_led(input logic tick, output led_level_t lvl);
        logic [31:0] slot;
        if (breath_len == '0)
            phase_ms = '0;
        else
            phase_ms = phase_ms % breath_len;
        if (tick)
        begin
            if (since_ms != SINCE_MAX)
                since_ms = since_ms + 1'b1;
            if (breath_len != '0)
            begin
                phase_ms = phase_ms + 1'b1;
                if (phase_ms >= breath_len)
                    phase_ms = '0;
            end
        end
        case (cur_mode)
            MODE_OFF: duty_now = '0;
            MODE_ON:  duty_now = DUTY_FULL;
            MODE_FLASH:
            begin
                if (lit_now && since_ms > SINCE_W'(lit_ms))
                begin
                    duty_now = '0;
                    since_ms = '0;
                    lit_now  = 1'b0;
                end
                if (!lit_now && since_ms > SINCE_W'(dark_ms))
                begin
                    duty_now = DUTY_FULL;
                    since_ms = '0;
                    lit_now  = 1'b1;
                end
            end
            default:
            begin
                if (breath_len == '0)
                    duty_now = DUTY_MID;
                else
                begin
                    slot     = (32'(phase_ms) * 32'(SINE_ENTRIES)) / 32'(breath_len);
                    duty_now = sine_level(slot);
                end
            end
        endcase
        lvl.duty = duty_now;
        lvl.lit  = lit_now;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 50)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        led_level_t lvl;
        if (!rst_n)
        begin
            cur_mode   = MODE_OFF;
            lit_ms     = '0;
            dark_ms    = '0;
            breath_len = '0;
            duty_now   = '0;
            lit_now    = 1'b0;
            since_ms   = '0;
            phase_ms   = '0;
            fail_count = 0;
            beats_in   = 0;
            beats_out  = 0;
            expected_levels.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_out++;
                if (expected_levels.size() == 0)
                    report_mismatch("result beat with nothing pending, duty_level",
                                    int'(m_tdata[DUTY_W-1:0]), -1);
                else
                begin
                    lvl = expected_levels.pop_front();
                    if (m_tdata[DUTY_W-1:0] !== lvl.duty)
                        report_mismatch("duty_level", int'(m_tdata[DUTY_W-1:0]), int'(lvl.duty));
                    if (m_tdata[DUTY_W] !== lvl.lit)
                        report_mismatch("flash_lit", int'(m_tdata[DUTY_W]), int'(lvl.lit));
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                beats_in++;
                advance_led(s_tdata[0], lvl);
                expected_levels.push_back(lvl);
            end
        end
        pending = expected_levels.size();
    end

endmodule

// File: bench/tb.sv
// Top of the LED flash and breathing driver testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfbd_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TIME_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int beats_in;
    int beats_out;
    int feed_idle_pct;
    int drain_idle_pct;
    int stall_requests;

    led_flash_and_breathe_driver_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_duty_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_in   (beats_in),
        .beats_out  (beats_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // The long hold-off is counted here so the sender keeps offering beats meanwhile.
    initial
    begin : drain
        int stall_served;
        int hold_left;
        m_tready     = 1'b0;
        stall_served = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                hold_left    = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    task automatic send_tick(input logic tick);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(tick);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                sec;
        int                i;
        int                tick_pct;
        logic [TIME_W-1:0] lit_v;
        logic [TIME_W-1:0] dark_v;
        logic [TIME_W-1:0] per_v;
        mode_t             mode_v;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        feed_idle_pct  = 6;
        drain_idle_pct = 64;
        stall_requests = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset state, then forced on.
        send_tick(1'b0);
        send_tick(1'b1);
        wait_quiet();
        cfg_write(REG_LED_MODE, TIME_W'(MODE_ON));
        cfg_valid <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);

        // Flashing entered from on keeps the old duty until the first phase change.
        wait_quiet();
        cfg_write(REG_LIT_TIME, 16'd2);
        cfg_write(REG_DARK_TIME, 16'd1);
        cfg_write(REG_LED_MODE, TIME_W'(MODE_FLASH));
        cfg_valid <= 1'b0;
        for (i = 0; i < 8; i++)
            send_tick(i != 4);

        // Breathing with a zero period gives the midpoint duty.
        wait_quiet();
        cfg_write(REG_BREATH_PERIOD, 16'd0);
        cfg_write(REG_LED_MODE, TIME_W'(MODE_BREATH));
        cfg_valid <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);

        // A period change needs no restart; unknown register indexes are ignored.
        wait_quiet();
        cfg_write(REG_BREATH_PERIOD, 16'd6);
        cfg_write(CFG_IDX_W'(4), 16'hFFFF);
        cfg_write({CFG_IDX_W{1'b1}}, 16'h1234);
        cfg_valid <= 1'b0;
        for (i = 0; i < 6; i++)
            send_tick(i != 5);

        // Lowering the period below the running phase wraps the phase.
        wait_quiet();
        cfg_write(REG_BREATH_PERIOD, 16'd3);
        cfg_valid <= 1'b0;
        send_tick(1'b1);

        for (sec = 0; sec < 12; sec++)
        begin
            wait_quiet();
            if (sec < 4)
            begin
                feed_idle_pct  = 6;
                drain_idle_pct = 64;
            end
            else if (sec < 8)
            begin
                feed_idle_pct  = 64;
                drain_idle_pct = 6;
            end
            else
            begin
                feed_idle_pct  = 0;
                drain_idle_pct = 0;
            end
            if (sec < 8)
                mode_v = mode_t'(sec % 4);
            else
                mode_v = mode_t'($urandom_range(2, 3));
            lit_v  = 16'($urandom_range(0, 6));
            dark_v = 16'($urandom_range(0, 6));
            per_v  = 16'($urandom_range(1, 300));
            if (sec == 2)
            begin
                lit_v  = 16'hFFFF;
                dark_v = 16'd0;
            end
            if (sec == 6)
            begin
                lit_v  = 16'd0;
                dark_v = 16'hFFFF;
            end
            if (sec == 3)
                per_v = 16'hFFFF;
            if (sec == 11)
                per_v = 16'd1;
            cfg_write(REG_LIT_TIME, lit_v);
            cfg_write(REG_DARK_TIME, dark_v);
            cfg_write(REG_BREATH_PERIOD, per_v);
            if ($urandom_range(2) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom));
            cfg_write(REG_LED_MODE, {14'($urandom), mode_v});
            cfg_valid <= 1'b0;
            tick_pct = (sec % 3 == 0) ? 50 : 90;
            if (sec == 1 || sec == 9)
                stall_requests++;
            for (i = 0; i < 50; i++)
            begin
                if (i == 25 && mode_v == MODE_BREATH && per_v > 16'd1)
                begin
                    wait_quiet();
                    cfg_write(REG_BREATH_PERIOD, 16'($urandom_range(1, int'(per_v) - 1)));
                    cfg_valid <= 1'b0;
                end
                send_tick($urandom_range(99) < tick_pct);
            end
        end

        wait_quiet();
        $display("Covered %0d tick beats and %0d checked result beats in all four modes,",
                 beats_in, beats_out);
        $display("with flash and period extremes, period rewrites and long output stalls.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
